>>> design/pswt_pkg.sv
// ----------------------------------------------------------------------------
// pswt_pkg
// Shared types, constants and the control store of the priority scheduler.
// ----------------------------------------------------------------------------
package pswt_pkg;

  // Fixed field widths of the words on the ports.
  localparam int BURST_W = 10;
  localparam int PRIO_W  = 10;
  localparam int ID_W    = 5;
  localparam int TIME_W  = 14;

  // Largest burst that fits the burst field, used to size the time sums.
  localparam int BURST_MAX = 1023;

  // Time results saturate at this value.
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One stored process.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } ent_t;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_SORT_INIT,
    OP_RD_I,
    OP_LAT_I,
    OP_RD_J,
    OP_CMP_J,
    OP_WR_I,
    OP_WR_SEL,
    OP_SUM_INIT,
    OP_ACC,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_AVG_W,
    OP_AVG_T,
    OP_EMIT,
    OP_FIN
  } op_e;

  // Hold condition: the step repeats until it is met.
  typedef enum logic [1:0] {
    W_NONE,
    W_IN_LAST,
    W_OUT_FREE
  } wait_e;

  // Branch condition: when true the step counter loads the target.
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_SCAN_DONE,
    C_J_MORE,
    C_I_MORE,
    C_K_MORE
  } cond_e;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_e   op;
    wait_e wt;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  // Step addresses of the program.
  localparam pc_t P_IDLE     = 5'd0;
  localparam pc_t P_SINIT    = 5'd1;
  localparam pc_t P_RDI      = 5'd2;
  localparam pc_t P_LATI     = 5'd3;
  localparam pc_t P_RDJ      = 5'd4;
  localparam pc_t P_CMPJ     = 5'd5;
  localparam pc_t P_SWAP1    = 5'd6;
  localparam pc_t P_SWAP2    = 5'd7;
  localparam pc_t P_SUMI     = 5'd8;
  localparam pc_t P_SRD      = 5'd9;
  localparam pc_t P_SACC     = 5'd10;
  localparam pc_t P_DW_INIT  = 5'd11;
  localparam pc_t P_DW_STEP  = 5'd12;
  localparam pc_t P_DW_END   = 5'd13;
  localparam pc_t P_DT_STEP  = 5'd14;
  localparam pc_t P_DT_END   = 5'd15;
  localparam pc_t P_ERD      = 5'd16;
  localparam pc_t P_EMIT     = 5'd17;
  localparam pc_t P_FIN      = 5'd18;

  // Control store.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      P_IDLE:    w = '{OP_LOAD,      W_IN_LAST,  C_NEXT,      P_IDLE};
      P_SINIT:   w = '{OP_SORT_INIT, W_NONE,     C_NEXT,      P_IDLE};
      P_RDI:     w = '{OP_RD_I,      W_NONE,     C_NEXT,      P_IDLE};
      P_LATI:    w = '{OP_LAT_I,     W_NONE,     C_SCAN_DONE, P_SWAP1};
      P_RDJ:     w = '{OP_RD_J,      W_NONE,     C_NEXT,      P_IDLE};
      P_CMPJ:    w = '{OP_CMP_J,     W_NONE,     C_J_MORE,    P_RDJ};
      P_SWAP1:   w = '{OP_WR_I,      W_NONE,     C_NEXT,      P_IDLE};
      P_SWAP2:   w = '{OP_WR_SEL,    W_NONE,     C_I_MORE,    P_RDI};
      P_SUMI:    w = '{OP_SUM_INIT,  W_NONE,     C_NEXT,      P_IDLE};
      P_SRD:     w = '{OP_RD_I,      W_NONE,     C_NEXT,      P_IDLE};
      P_SACC:    w = '{OP_ACC,       W_NONE,     C_I_MORE,    P_SRD};
      P_DW_INIT: w = '{OP_DIV_LD,    W_NONE,     C_NEXT,      P_IDLE};
      P_DW_STEP: w = '{OP_DIV_STEP,  W_NONE,     C_K_MORE,    P_DW_STEP};
      P_DW_END:  w = '{OP_AVG_W,     W_NONE,     C_NEXT,      P_IDLE};
      P_DT_STEP: w = '{OP_DIV_STEP,  W_NONE,     C_K_MORE,    P_DT_STEP};
      P_DT_END:  w = '{OP_AVG_T,     W_NONE,     C_NEXT,      P_IDLE};
      P_ERD:     w = '{OP_RD_I,      W_NONE,     C_NEXT,      P_IDLE};
      P_EMIT:    w = '{OP_EMIT,      W_OUT_FREE, C_I_MORE,    P_ERD};
      P_FIN:     w = '{OP_FIN,       W_NONE,     C_GOTO,      P_IDLE};
      default:   w = '{OP_FIN,       W_NONE,     C_GOTO,      P_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> design/priority_schedule_wait_times_core.sv
// ----------------------------------------------------------------------------
// priority_schedule_wait_times_core
// Non-preemptive priority scheduler computing wait and turnaround times.
// ----------------------------------------------------------------------------
// The block takes one process word per cycle (burst time, priority value)
// and numbers the processes from 1 in arrival order; words beyond MAX_PROCS
// are dropped and reported through the overflow bit of every result of the
// set. The word flagged last_item starts the schedule. From then on the
// input stays stalled until the whole set has been delivered: a selection
// sort orders the stored set by ascending priority value (first strictly
// smallest entry wins, then a swap), a summing pass builds the total wait
// and turnaround, a bit-serial divider forms both averages, and one result
// word per process is emitted in schedule order, the averages and
// last_result on the final one. The divider works on sums SUMW bits wide,
// the width of the turnaround sum (18 bits at MAX_PROCS = 16). The sort's
// compare loop over the single-read-port process memory dominates the
// schedule time of a full set. Each result word sits in an output
// register, so the sequencer prepares the next one while it waits.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_core
  import pswt_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRIO_W-1:0]  in_prio_value,
  input  logic               in_last_item,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_process_number,
  output logic [BURST_W-1:0] out_burst_out,
  output logic [PRIO_W-1:0]  out_prio_out,
  output logic [TIME_W-1:0]  out_waiting_time,
  output logic [TIME_W-1:0]  out_turnaround_time,
  output logic [TIME_W-1:0]  out_avg_wait,
  output logic [TIME_W-1:0]  out_avg_turnaround,
  output logic               out_overflow,
  output logic               out_last_result
);

  // Index width for the process memory, and a count width that can also
  // hold MAX_PROCS itself.
  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  // A running wait or a turnaround is at most MAX_PROCS full bursts. The
  // sum of all turnarounds is at most a triangular number of bursts. Both
  // are kept at least as wide as the result fields so saturation is a
  // plain compare.
  localparam int WAIT_RAW = $clog2(MAX_PROCS * BURST_MAX + 1);
  localparam int WAIT_W   = (WAIT_RAW > TIME_W) ? WAIT_RAW : TIME_W;
  localparam int SUM_RAW  = $clog2((MAX_PROCS * (MAX_PROCS + 1) / 2) * BURST_MAX + 1);
  localparam int SUMW     = (SUM_RAW > TIME_W) ? SUM_RAW : TIME_W;
  localparam int KW       = $clog2(SUMW);

  // Process memory: one write port, one registered read port.
  ent_t ent_mem [MAX_PROCS];

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  ent_t          mem_wdata;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  // Sequencer and datapath registers.
  pc_t                pc_r, pc_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               drop_r, drop_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [IW-1:0]      sel_r, sel_nxt;
  ent_t               rdata_r;
  ent_t               ent_i_r, ent_i_nxt;
  ent_t               best_r, best_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [SUMW-1:0]    wsum_r, wsum_nxt;
  logic [SUMW-1:0]    tsum_r, tsum_nxt;
  logic [SUMW-1:0]    div_r, div_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [TIME_W-1:0]  avgw_r, avgw_nxt;
  logic [TIME_W-1:0]  avgt_r, avgt_nxt;

  // Output register.
  logic               o_valid_r, o_valid_nxt;
  logic [ID_W-1:0]    o_num_r, o_num_nxt;
  logic [BURST_W-1:0] o_burst_r, o_burst_nxt;
  logic [PRIO_W-1:0]  o_prio_r, o_prio_nxt;
  logic [TIME_W-1:0]  o_wait_r, o_wait_nxt;
  logic [TIME_W-1:0]  o_tat_r, o_tat_nxt;
  logic [TIME_W-1:0]  o_avgw_r, o_avgw_nxt;
  logic [TIME_W-1:0]  o_avgt_r, o_avgt_nxt;
  logic               o_ovf_r, o_ovf_nxt;
  logic               o_last_r, o_last_nxt;

  // Decoded control and conditions.
  ucode_t             uc;
  logic               acc_in;
  logic               out_free;
  logic               held;
  logic               go;
  logic               j_more;
  logic               i_more;
  logic               k_more;
  logic               scan_done;
  logic [WAIT_W-1:0]  burst_ext;
  logic [WAIT_W-1:0]  tat_w;
  logic [CW:0]        rem_sh;
  logic               rem_ge;
  logic [TIME_W-1:0]  div_sat;

  assign uc       = ucode_rom(pc_r);
  assign in_ready = (uc.op == OP_LOAD);
  assign acc_in   = in_valid && in_ready;
  assign out_free = !o_valid_r || out_ready;

  // A step that waits for a free output register repeats itself without
  // side effects; the load step stores accepted words until the last one.
  assign held = ((uc.wt == W_IN_LAST) && !(acc_in && in_last_item)) ||
                ((uc.wt == W_OUT_FREE) && !out_free);
  assign go   = !held;

  assign j_more    = (({1'b0, j_r} + (CW + 1)'(1)) < {1'b0, cnt_r});
  assign i_more    = (({1'b0, i_r} + (CW + 1)'(1)) < {1'b0, cnt_r});
  assign k_more    = (k_r != KW'(SUMW - 1));
  assign scan_done = (j_r >= cnt_r);

  assign burst_ext = WAIT_W'(rdata_r.burst);
  assign tat_w     = wait_r + burst_ext;

  // One restoring division step: shift in the next dividend bit and
  // subtract the process count when it fits.
  assign rem_sh  = {rem_r, div_r[SUMW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, cnt_r});
  assign div_sat = (div_r > SUMW'(TIME_MAX)) ? TIME_MAX : div_r[TIME_W-1:0];

  // Step counter.
  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      case (uc.cond)
        C_NEXT:      pc_nxt = pc_r + PC_W'(1);
        C_GOTO:      pc_nxt = uc.target;
        C_SCAN_DONE: pc_nxt = scan_done ? uc.target : pc_r + PC_W'(1);
        C_J_MORE:    pc_nxt = j_more ? uc.target : pc_r + PC_W'(1);
        C_I_MORE:    pc_nxt = i_more ? uc.target : pc_r + PC_W'(1);
        C_K_MORE:    pc_nxt = k_more ? uc.target : pc_r + PC_W'(1);
        default:     pc_nxt = P_IDLE;
      endcase
    end
  end

  // Datapath driven by the current control word.
  always_comb begin
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sel_nxt   = sel_r;
    ent_i_nxt = ent_i_r;
    best_nxt  = best_r;
    wait_nxt  = wait_r;
    wsum_nxt  = wsum_r;
    tsum_nxt  = tsum_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    avgw_nxt  = avgw_r;
    avgt_nxt  = avgt_r;
    mem_we    = 1'b0;
    mem_waddr = i_r[IW-1:0];
    mem_wdata = best_r;
    rd_en     = 1'b0;
    rd_addr   = i_r[IW-1:0];

    o_valid_nxt = o_valid_r && !out_ready;
    o_num_nxt   = o_num_r;
    o_burst_nxt = o_burst_r;
    o_prio_nxt  = o_prio_r;
    o_wait_nxt  = o_wait_r;
    o_tat_nxt   = o_tat_r;
    o_avgw_nxt  = o_avgw_r;
    o_avgt_nxt  = o_avgt_r;
    o_ovf_nxt   = o_ovf_r;
    o_last_nxt  = o_last_r;

    unique case (uc.op)
      OP_LOAD: begin
        if (acc_in) begin
          if (cnt_r < CW'(MAX_PROCS)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[IW-1:0];
            mem_wdata = '{id:    ID_W'(cnt_r + CW'(1)),
                          prio:  in_prio_value,
                          burst: in_burst_time};
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      OP_SORT_INIT: begin
        i_nxt = '0;
      end
      OP_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_r[IW-1:0];
        j_nxt   = i_r + CW'(1);
        sel_nxt = i_r[IW-1:0];
      end
      OP_LAT_I: begin
        ent_i_nxt = rdata_r;
        best_nxt  = rdata_r;
      end
      OP_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = j_r[IW-1:0];
      end
      OP_CMP_J: begin
        // Strictly smaller only, so the earliest of equal entries stays.
        if (rdata_r.prio < best_r.prio) begin
          best_nxt = rdata_r;
          sel_nxt  = j_r[IW-1:0];
        end
        j_nxt = j_r + CW'(1);
      end
      OP_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[IW-1:0];
        mem_wdata = best_r;
      end
      OP_WR_SEL: begin
        mem_we    = 1'b1;
        mem_waddr = sel_r;
        mem_wdata = ent_i_r;
        i_nxt     = i_r + CW'(1);
      end
      OP_SUM_INIT: begin
        i_nxt    = '0;
        wait_nxt = '0;
        wsum_nxt = '0;
        tsum_nxt = '0;
      end
      OP_ACC: begin
        wsum_nxt = wsum_r + SUMW'(wait_r);
        tsum_nxt = tsum_r + SUMW'(tat_w);
        wait_nxt = tat_w;
        i_nxt    = i_r + CW'(1);
      end
      OP_DIV_LD: begin
        div_nxt = wsum_r;
        rem_nxt = '0;
        k_nxt   = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt = rem_ge ? CW'(rem_sh - {1'b0, cnt_r}) : rem_sh[CW-1:0];
        div_nxt = {div_r[SUMW-2:0], rem_ge};
        k_nxt   = k_r + KW'(1);
      end
      OP_AVG_W: begin
        avgw_nxt = div_sat;
        div_nxt  = tsum_r;
        rem_nxt  = '0;
        k_nxt    = '0;
      end
      OP_AVG_T: begin
        avgt_nxt = div_sat;
        i_nxt    = '0;
        wait_nxt = '0;
      end
      OP_EMIT: begin
        if (go) begin
          o_valid_nxt = 1'b1;
          o_num_nxt   = rdata_r.id;
          o_burst_nxt = rdata_r.burst;
          o_prio_nxt  = rdata_r.prio;
          o_wait_nxt  = (wait_r > WAIT_W'(TIME_MAX)) ? TIME_MAX : wait_r[TIME_W-1:0];
          o_tat_nxt   = (tat_w > WAIT_W'(TIME_MAX)) ? TIME_MAX : tat_w[TIME_W-1:0];
          o_avgw_nxt  = i_more ? '0 : avgw_r;
          o_avgt_nxt  = i_more ? '0 : avgt_r;
          o_ovf_nxt   = drop_r;
          o_last_nxt  = !i_more;
          wait_nxt    = tat_w;
          i_nxt       = i_r + CW'(1);
        end
      end
      OP_FIN: begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Process memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= ent_mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= P_IDLE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    sel_r    <= sel_nxt;
    ent_i_r  <= ent_i_nxt;
    best_r   <= best_nxt;
    wait_r   <= wait_nxt;
    wsum_r   <= wsum_nxt;
    tsum_r   <= tsum_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    k_r      <= k_nxt;
    avgw_r   <= avgw_nxt;
    avgt_r   <= avgt_nxt;
    o_num_r   <= o_num_nxt;
    o_burst_r <= o_burst_nxt;
    o_prio_r  <= o_prio_nxt;
    o_wait_r  <= o_wait_nxt;
    o_tat_r   <= o_tat_nxt;
    o_avgw_r  <= o_avgw_nxt;
    o_avgt_r  <= o_avgt_nxt;
    o_ovf_r   <= o_ovf_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid           = o_valid_r;
  assign out_process_number  = o_num_r;
  assign out_burst_out       = o_burst_r;
  assign out_prio_out        = o_prio_r;
  assign out_waiting_time    = o_wait_r;
  assign out_turnaround_time = o_tat_r;
  assign out_avg_wait        = o_avgw_r;
  assign out_avg_turnaround  = o_avgt_r;
  assign out_overflow        = o_ovf_r;
  assign out_last_result     = o_last_r;

`ifndef SYNTHESIS
  // The stored count never passes the memory depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PROCS))
    else $error("process count exceeds capacity");

  // An accepted last word always starts the sort.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_last_item |=> pc_r == P_SINIT)
    else $error("last word did not start scheduling");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uc.op == OP_DIV_STEP |-> rem_r < cnt_r)
    else $error("divider remainder out of range");

  // The swap partner is always a stored entry.
  a_sel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uc.op == OP_WR_SEL |-> {1'b0, sel_r} < (IW + 1)'(cnt_r))
    else $error("swap index beyond stored set");

  // Emitting the final result of a set leads straight to clearing it.
  a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    uc.op == OP_EMIT && go && !i_more |=> pc_r == P_FIN && o_last_r)
    else $error("final result not followed by set clear");
`endif

endmodule

>>> tb/priority_schedule_wait_times_core_tb.sv
// ----------------------------------------------------------------------------
// priority_schedule_wait_times_core_tb
// Self-checking bench for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
// Process words are fed through the input channel from a queue. Every
// accepted word also goes into a behavioral copy of the scheduler. That copy
// keeps its own process store, sorts with the same swap-based selection
// sort, and queues one expected schedule word per process. A monitor checks
// each delivered schedule word, field by field, against the oldest entry in
// that queue. Both sides stall at random, and once the receiver holds off
// long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pswt_pkg::*;

  localparam int MAX_PROCS      = 16;
  localparam int RANDOM_WORDS   = 180;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 100;

  // One process word as offered on the input channel.
  typedef struct {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               is_last;
  } proc_word_t;

  // One schedule word as expected on the output channel.
  typedef struct {
    logic [ID_W-1:0]    pnum;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  tat_time;
    logic [TIME_W-1:0]  avg_w;
    logic [TIME_W-1:0]  avg_t;
    logic               ovf;
    logic               is_last;
  } sched_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BURST_W-1:0] in_burst_time = '0;
  logic [PRIO_W-1:0]  in_prio_value = '0;
  logic               in_last_item = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ID_W-1:0]    out_process_number;
  logic [BURST_W-1:0] out_burst_out;
  logic [PRIO_W-1:0]  out_prio_out;
  logic [TIME_W-1:0]  out_waiting_time;
  logic [TIME_W-1:0]  out_turnaround_time;
  logic [TIME_W-1:0]  out_avg_wait;
  logic [TIME_W-1:0]  out_avg_turnaround;
  logic               out_overflow;
  logic               out_last_result;

  priority_schedule_wait_times_core #(
    .MAX_PROCS (MAX_PROCS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_burst_time       (in_burst_time),
    .in_prio_value       (in_prio_value),
    .in_last_item        (in_last_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_process_number  (out_process_number),
    .out_burst_out       (out_burst_out),
    .out_prio_out        (out_prio_out),
    .out_waiting_time    (out_waiting_time),
    .out_turnaround_time (out_turnaround_time),
    .out_avg_wait        (out_avg_wait),
    .out_avg_turnaround  (out_avg_turnaround),
    .out_overflow        (out_overflow),
    .out_last_result     (out_last_result)
  );

  // Words waiting to be offered, and schedule words waiting to be seen.
  proc_word_t  pending_procs[$];
  sched_word_t sched_expect_q[$];

  // Behavioral copy of the block's process store.
  logic [BURST_W-1:0] held_burst[MAX_PROCS];
  logic [PRIO_W-1:0]  held_prio[MAX_PROCS];
  logic [ID_W-1:0]    held_id[MAX_PROCS];
  int                 held_count = 0;
  logic               held_dropped = 1'b0;

  int error_count;
  int words_sent;
  int results_seen;
  int sets_scheduled;
  int overflow_sets;
  int hold_left;
  bit hold_done;
  int idle_cycles = 0;
  logic [31:0] cycle_count = '0;

  // In these windows neither side ever idles, so the block also sees
  // back-to-back traffic over long stretches.
  logic calm;
  assign calm = (cycle_count % 3000) < 800;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] clip_time(input int unsigned v);
    return (v > TIME_MAX) ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  // Loads one accepted process word into the behavioral store. A word marked
  // last then schedules the stored set: selection sort on the priority value
  // (first strictly smallest wins, then a swap, which is what reorders ties),
  // followed by the running wait sums and the truncated averages.
  task automatic take_process(input proc_word_t w);
    sched_word_t        r;
    int                 n;
    int                 sel;
    int unsigned        wait_acc;
    int unsigned        tat;
    int unsigned        wsum;
    int unsigned        tsum;
    logic [BURST_W-1:0] tb;
    logic [PRIO_W-1:0]  tp;
    logic [ID_W-1:0]    ti;
    if (held_count < MAX_PROCS) begin
      held_burst[held_count] = w.burst;
      held_prio[held_count]  = w.prio;
      held_id[held_count]    = ID_W'(held_count + 1);
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!w.is_last) return;

    n = held_count;
    for (int i = 0; i < n; i++) begin
      sel = i;
      for (int j = i + 1; j < n; j++)
        if (held_prio[j] < held_prio[sel]) sel = j;
      tb = held_burst[i]; held_burst[i] = held_burst[sel]; held_burst[sel] = tb;
      tp = held_prio[i];  held_prio[i]  = held_prio[sel];  held_prio[sel]  = tp;
      ti = held_id[i];    held_id[i]    = held_id[sel];    held_id[sel]    = ti;
    end

    wait_acc = 0;
    wsum     = 0;
    tsum     = 0;
    for (int i = 0; i < n; i++) begin
      tat         = held_burst[i] + wait_acc;
      r.pnum      = held_id[i];
      r.burst     = held_burst[i];
      r.prio      = held_prio[i];
      r.wait_time = clip_time(wait_acc);
      r.tat_time  = clip_time(tat);
      r.avg_w     = '0;
      r.avg_t     = '0;
      r.ovf       = held_dropped;
      r.is_last   = 1'b0;
      wsum       += wait_acc;
      tsum       += tat;
      wait_acc   += held_burst[i];
      if (i == n - 1) begin
        r.avg_w   = clip_time(wsum / n);
        r.avg_t   = clip_time(tsum / n);
        r.is_last = 1'b1;
      end
      sched_expect_q.push_back(r);
    end
    sets_scheduled++;
    if (held_dropped) overflow_sets++;
    held_count   = 0;
    held_dropped = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic add_proc(input int burst, input int prio, input bit is_last);
    proc_word_t w;
    w.burst   = BURST_W'(burst);
    w.prio    = PRIO_W'(prio);
    w.is_last = is_last;
    pending_procs.push_back(w);
  endtask

  // Driver: the payload stays put until the word is taken. A new word is only
  // presented when the slot is free, and then at most once per edge.
  always @(posedge clk) begin
    proc_word_t taken;
    proc_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.burst   = in_burst_time;
        taken.prio    = in_prio_value;
        taken.is_last = in_last_item;
        take_process(taken);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_procs.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          nxt = pending_procs.pop_front();
          in_valid      <= 1'b1;
          in_burst_time <= nxt.burst;
          in_prio_value <= nxt.prio;
          in_last_item  <= nxt.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every delivered schedule word and drives out_ready. Once
  // during the run it holds out_ready low for a long stretch so that the
  // block has to stall its input while the driver keeps offering words.
  always @(posedge clk) begin
    sched_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (sched_expect_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected schedule word, expected none, actual process %0d",
                   $time, out_process_number);
        end else begin
          e = sched_expect_q.pop_front();
          check_field("process_number",  e.pnum,      out_process_number);
          check_field("burst_out",       e.burst,     out_burst_out);
          check_field("prio_out",        e.prio,      out_prio_out);
          check_field("waiting_time",    e.wait_time, out_waiting_time);
          check_field("turnaround_time", e.tat_time,  out_turnaround_time);
          check_field("avg_wait",        e.avg_w,     out_avg_wait);
          check_field("avg_turnaround",  e.avg_t,     out_avg_turnaround);
          check_field("overflow",        e.ovf,       out_overflow);
          check_field("last_result",     e.is_last,   out_last_result);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on either side means
  // the block has hung. The longest legal quiet spell is a full set being
  // sorted, or the receiver hold-off, both far below the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rand_words;
    int n;
    bit narrow;
    int burst;
    rst_n = 1'b0;

    // Single-process sets with all fields at zero and at 999.
    add_proc(0, 0, 1'b1);
    add_proc(999, 999, 1'b1);
    // Equal priorities: the swap-based sort moves tied processes around.
    add_proc(100, 5, 1'b0);
    add_proc(200, 1, 1'b0);
    add_proc(300, 5, 1'b0);
    add_proc(400, 1, 1'b1);
    // Priorities arriving in reverse order.
    add_proc(999, 999, 1'b0);
    add_proc(1, 512, 1'b0);
    add_proc(512, 0, 1'b1);
    // More words than the store holds, all with a burst of 999, so the
    // sums grow large. The last word itself is dropped but
    // still starts the schedule.
    for (int i = 0; i < MAX_PROCS + 2; i++)
      add_proc(999, 999 - 55 * i, i == MAX_PROCS + 1);

    // Random sets: mostly small, now and then full or overflowing. Narrow
    // priority ranges make ties frequent.
    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      n      = ($urandom_range(0, 9) == 0) ? MAX_PROCS + $urandom_range(0, 3)
                                           : $urandom_range(1, 6);
      narrow = $urandom_range(0, 2) == 0;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0:       burst = 0;
          1:       burst = 999;
          default: burst = $urandom_range(0, 999);
        endcase
        add_proc(burst, narrow ? $urandom_range(0, 3) : $urandom_range(0, 999), i == n - 1);
      end
      rand_words += n;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every word is marked-last terminated, so once all words are in and all
    // schedule words are out, nothing else may appear.
    while (pending_procs.size() != 0 || in_valid || sched_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d process words in %0d sets (%0d with dropped words).",
             words_sent, sets_scheduled, overflow_sets);
    $display("Checked %0d schedule words, %0d field mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
